// File: hdl/hsv_to_rgb_converter_assert.svh
// Assertion macros of the HSV to RGB converter checker.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication on clk, off during reset
`define HSV2RGB_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsv_to_rgb_converter: same-cycle check failed");

// next-cycle implication on clk, off during reset
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsv_to_rgb_converter: next-cycle check failed");

`endif

// File: hdl/hsv2rgb_pkg.sv
// Shared constants and types of the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int FRACTION_BITS = 6;
	localparam int ONE_Q = 1 << FRACTION_BITS;

	localparam int IDX_W = 8;
	localparam int HUE_W = 15;
	localparam int PCT_W = 13;
	localparam int LVL_W = 8;
	localparam int FN_W = 12;
	localparam int X_W = 25;
	localparam int M_W = PCT_W + X_W;

	// denominator = DEN_CORE * 2^DEN_SHIFT
	localparam int DEN_SHIFT = 3 * FRACTION_BITS;
	localparam int DEN_CORE = 100 * 100 * 60;
	localparam int DEN_W = 20;
	localparam int Y_W = M_W + LVL_W - DEN_SHIFT;

	// reciprocal of DEN_CORE, quotient may come out one low
	localparam int RECIP_SHIFT = 40;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DEN_CORE;
	localparam int RECIP_W = 21;
	localparam int YK_W = Y_W + RECIP_W;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 32;

	localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(360 * ONE_Q);
	localparam logic [HUE_W-1:0] SECTOR_W = HUE_W'(60 * ONE_Q);
	localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100 * ONE_Q);
	localparam logic [X_W-1:0] X_FULL = X_W'(100 * ONE_Q * 60 * ONE_Q);

	typedef enum logic [2:0] {
		SEC_RED_YEL,
		SEC_YEL_GRN,
		SEC_GRN_CYN,
		SEC_CYN_BLU,
		SEC_BLU_MAG,
		SEC_MAG_RED
	} sector_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

// File: hdl/hsv2rgb_sector.sv
// Stage 1: input clamping, hue sector and offset within the sector.
module hsv2rgb_sector (
	input  logic                            clk,
	input  hsv2rgb_pkg::stage_en_t          en,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]   sat,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]   bri,
	output hsv2rgb_pkg::sector_t            sector_s1,
	output logic [hsv2rgb_pkg::FN_W-1:0]    fn_s1,
	output logic [hsv2rgb_pkg::PCT_W-1:0]   sat_s1,
	output logic [hsv2rgb_pkg::PCT_W-1:0]   bri_s1
);

	logic [hsv2rgb_pkg::HUE_W-1:0] hue_c;
	logic [hsv2rgb_pkg::HUE_W-1:0] base_c;
	hsv2rgb_pkg::sector_t          sec_c;

	assign hue_c = (hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : hue;

	// full circle wraps to the first sector with zero offset
	always_comb begin
		if (hue_c >= hsv2rgb_pkg::HUE_MAX) begin
			sec_c  = hsv2rgb_pkg::SEC_RED_YEL;
			base_c = hsv2rgb_pkg::HUE_MAX;
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_c  = hsv2rgb_pkg::SEC_MAG_RED;
			base_c = hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_W);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_c  = hsv2rgb_pkg::SEC_BLU_MAG;
			base_c = hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_W);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_c  = hsv2rgb_pkg::SEC_CYN_BLU;
			base_c = hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_W);
		end else if (hue_c >= hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_c  = hsv2rgb_pkg::SEC_GRN_CYN;
			base_c = hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_W);
		end else if (hue_c >= hsv2rgb_pkg::SECTOR_W) begin
			sec_c  = hsv2rgb_pkg::SEC_YEL_GRN;
			base_c = hsv2rgb_pkg::SECTOR_W;
		end else begin
			sec_c  = hsv2rgb_pkg::SEC_RED_YEL;
			base_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sector_s1 <= sec_c;
			fn_s1     <= hsv2rgb_pkg::FN_W'(hue_c - base_c);
			sat_s1    <= (sat > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : sat;
			bri_s1    <= (bri > hsv2rgb_pkg::PCT_MAX) ? hsv2rgb_pkg::PCT_MAX : bri;
		end
	end

endmodule

// File: hdl/hsv2rgb_mix.sv
// Stages 2 and 3: per-channel chroma terms by sector, then scaling by value.
module hsv2rgb_mix (
	input  logic                            clk,
	input  hsv2rgb_pkg::stage_en_t          en,
	input  hsv2rgb_pkg::sector_t            sector_s1,
	input  logic [hsv2rgb_pkg::FN_W-1:0]    fn_s1,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]   sat_s1,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]   bri_s1,
	output logic [hsv2rgb_pkg::M_W-1:0]     m_red_s3,
	output logic [hsv2rgb_pkg::M_W-1:0]     m_green_s3,
	output logic [hsv2rgb_pkg::M_W-1:0]     m_blue_s3
);

	logic [hsv2rgb_pkg::X_W-1:0]   sat_ext;
	logic [hsv2rgb_pkg::X_W-1:0]   fs_c;
	logic [hsv2rgb_pkg::X_W-1:0]   ft_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xv_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xp_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xq_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xt_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xr_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xg_c;
	logic [hsv2rgb_pkg::X_W-1:0]   xb_c;
	logic [hsv2rgb_pkg::X_W-1:0]   x_red_s2;
	logic [hsv2rgb_pkg::X_W-1:0]   x_green_s2;
	logic [hsv2rgb_pkg::X_W-1:0]   x_blue_s2;
	logic [hsv2rgb_pkg::PCT_W-1:0] bri_s2;

	assign sat_ext = hsv2rgb_pkg::X_W'(sat_s1);
	assign fs_c = hsv2rgb_pkg::X_W'(fn_s1) * sat_ext;
	assign ft_c = hsv2rgb_pkg::X_W'(hsv2rgb_pkg::SECTOR_W - hsv2rgb_pkg::HUE_W'(fn_s1)) * sat_ext;
	assign xv_c = hsv2rgb_pkg::X_FULL;
	assign xp_c = hsv2rgb_pkg::X_W'(hsv2rgb_pkg::PCT_MAX - sat_s1) *
		hsv2rgb_pkg::X_W'(hsv2rgb_pkg::SECTOR_W);
	assign xq_c = hsv2rgb_pkg::X_FULL - fs_c;
	assign xt_c = hsv2rgb_pkg::X_FULL - ft_c;

	always_comb begin
		unique case (sector_s1)
			hsv2rgb_pkg::SEC_RED_YEL: begin
				xr_c = xv_c; xg_c = xt_c; xb_c = xp_c;
			end
			hsv2rgb_pkg::SEC_YEL_GRN: begin
				xr_c = xq_c; xg_c = xv_c; xb_c = xp_c;
			end
			hsv2rgb_pkg::SEC_GRN_CYN: begin
				xr_c = xp_c; xg_c = xv_c; xb_c = xt_c;
			end
			hsv2rgb_pkg::SEC_CYN_BLU: begin
				xr_c = xp_c; xg_c = xq_c; xb_c = xv_c;
			end
			hsv2rgb_pkg::SEC_BLU_MAG: begin
				xr_c = xt_c; xg_c = xp_c; xb_c = xv_c;
			end
			default: begin
				xr_c = xv_c; xg_c = xp_c; xb_c = xq_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			x_red_s2   <= xr_c;
			x_green_s2 <= xg_c;
			x_blue_s2  <= xb_c;
			bri_s2     <= bri_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			m_red_s3   <= hsv2rgb_pkg::M_W'(bri_s2) * hsv2rgb_pkg::M_W'(x_red_s2);
			m_green_s3 <= hsv2rgb_pkg::M_W'(bri_s2) * hsv2rgb_pkg::M_W'(x_green_s2);
			m_blue_s3  <= hsv2rgb_pkg::M_W'(bri_s2) * hsv2rgb_pkg::M_W'(x_blue_s2);
		end
	end

endmodule

// File: hdl/hsv2rgb_scale.sv
// Stages 4 to 6: floor(255 * m / denominator) by reciprocal multiply and one correction.
module hsv2rgb_scale (
	input  logic                            clk,
	input  hsv2rgb_pkg::stage_en_t          en,
	input  logic [hsv2rgb_pkg::M_W-1:0]     m_s3,
	output logic [hsv2rgb_pkg::LVL_W-1:0]   level_s6
);

	localparam int N_W = hsv2rgb_pkg::M_W + hsv2rgb_pkg::LVL_W;

	logic [N_W-1:0]                      n_c;
	logic [hsv2rgb_pkg::Y_W-1:0]         y_s4;
	logic [hsv2rgb_pkg::YK_W-1:0]        yk_c;
	logic [hsv2rgb_pkg::Y_W-1:0]         y_s5;
	logic [hsv2rgb_pkg::LVL_W-1:0]       q0_s5;
	logic [hsv2rgb_pkg::Y_W-1:0]         qd_c;
	logic [hsv2rgb_pkg::Y_W-1:0]         rem_c;

	// 255 * m, then drop the power-of-two part of the denominator
	assign n_c = {m_s3, hsv2rgb_pkg::LVL_W'(0)} - N_W'(m_s3);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_s4 <= n_c[N_W-1 -: hsv2rgb_pkg::Y_W];
		end
	end

	assign yk_c = hsv2rgb_pkg::YK_W'(y_s4) * hsv2rgb_pkg::YK_W'(hsv2rgb_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			q0_s5 <= yk_c[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::LVL_W];
			y_s5  <= y_s4;
		end
	end

	assign qd_c  = hsv2rgb_pkg::Y_W'(q0_s5) * hsv2rgb_pkg::Y_W'(hsv2rgb_pkg::DEN_CORE);
	assign rem_c = y_s5 - qd_c;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			level_s6 <= (rem_c >= hsv2rgb_pkg::Y_W'(hsv2rgb_pkg::DEN_CORE)) ?
				hsv2rgb_pkg::LVL_W'(q0_s5 + hsv2rgb_pkg::LVL_W'(1)) : q0_s5;
		end
	end

endmodule

// File: hdl/hsv_to_rgb_converter.sv
// An accepted item passes stage registers s1 to s6 in order; m_tvalid is the s6
// valid bit. Throughput: one item per clock while m_tready is high; each of the
// six stages advances when it is empty or the next one advances, so bubbles close up and
// a stall holds data. Deepest logic per stage: one 38x38 (13x25 used) or 28x21 multiply.
// Reset clears the stage valid bits only; data registers are not reset.
// Top level of the HSV to RGB converter: handshake, valid chain and index path.
module hsv_to_rgb_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// led_index[7:0], hue_q6[22:8], saturation_q6[35:23], brightness_q6[48:36], zero
	input  logic [hsv2rgb_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// pixel_index[7:0], red_level[15:8], green_level[23:16], blue_level[31:24]
	output logic [hsv2rgb_pkg::M_TDATA_W-1:0]   m_tdata
);

	hsv2rgb_pkg::stage_en_t          en;
	logic                            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [hsv2rgb_pkg::IDX_W-1:0]   idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	hsv2rgb_pkg::sector_t            sector_s1;
	logic [hsv2rgb_pkg::FN_W-1:0]    fn_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0]   sat_s1;
	logic [hsv2rgb_pkg::PCT_W-1:0]   bri_s1;
	logic [hsv2rgb_pkg::M_W-1:0]     m_red_s3, m_green_s3, m_blue_s3;
	logic [hsv2rgb_pkg::LVL_W-1:0]   red_s6, green_s6, blue_s6;

	assign en.s6 = !v_s6 || m_tready;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign s_tready = en.s1;
	assign m_tvalid = v_s6;
	assign m_tdata  = {blue_s6, green_s6, red_s6, idx_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) idx_s1 <= s_tdata[7:0];
		if (en.s2) idx_s2 <= idx_s1;
		if (en.s3) idx_s3 <= idx_s2;
		if (en.s4) idx_s4 <= idx_s3;
		if (en.s5) idx_s5 <= idx_s4;
		if (en.s6) idx_s6 <= idx_s5;
	end

	hsv2rgb_sector u_sector (
		.clk       (clk),
		.en        (en),
		.hue       (s_tdata[22:8]),
		.sat       (s_tdata[35:23]),
		.bri       (s_tdata[48:36]),
		.sector_s1 (sector_s1),
		.fn_s1     (fn_s1),
		.sat_s1    (sat_s1),
		.bri_s1    (bri_s1)
	);

	hsv2rgb_mix u_mix (
		.clk        (clk),
		.en         (en),
		.sector_s1  (sector_s1),
		.fn_s1      (fn_s1),
		.sat_s1     (sat_s1),
		.bri_s1     (bri_s1),
		.m_red_s3   (m_red_s3),
		.m_green_s3 (m_green_s3),
		.m_blue_s3  (m_blue_s3)
	);

	hsv2rgb_scale u_scale_red (
		.clk      (clk),
		.en       (en),
		.m_s3     (m_red_s3),
		.level_s6 (red_s6)
	);

	hsv2rgb_scale u_scale_green (
		.clk      (clk),
		.en       (en),
		.m_s3     (m_green_s3),
		.level_s6 (green_s6)
	);

	hsv2rgb_scale u_scale_blue (
		.clk      (clk),
		.en       (en),
		.m_s3     (m_blue_s3),
		.level_s6 (blue_s6)
	);

endmodule

// File: hdl/hsv2rgb_checker.sv
// Port-level checks of the HSV to RGB converter and their bind.
`include "hsv_to_rgb_converter_assert.svh"

module hsv2rgb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [hsv2rgb_pkg::M_TDATA_W-1:0]   m_tdata
);

	`HSV2RGB_ASSERT_NEXT(a_out_valid_held, m_tvalid && !m_tready, m_tvalid)
	`HSV2RGB_ASSERT_NEXT(a_out_data_held, m_tvalid && !m_tready, $stable(m_tdata))
	`HSV2RGB_ASSERT_SAME(a_ready_when_out_empty, !m_tvalid, s_tready)
	`HSV2RGB_ASSERT_SAME(a_ready_when_out_taken, m_tready, s_tready)
	`HSV2RGB_ASSERT_NEXT(a_six_cycle_latency, s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid)

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
